// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the task-file command builder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while in reset
`define TFCB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked property checked during reset as well
`define TFCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/tfcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tfcb_pkg
// Types, codes and constants shared by the task-file command builder.
// ----------------------------------------------------------------------------
package tfcb_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 5;

   // configuration register indexes
   localparam logic [1:0] CSR_LBA28_CAPABLE = 2'd0;
   localparam logic [1:0] CSR_IS_SLAVE      = 2'd1;
   localparam logic [1:0] CSR_CHANNEL       = 2'd2;

   // addressing modes
   localparam logic [1:0] MODE_CHS   = 2'd0;
   localparam logic [1:0] MODE_LBA28 = 2'd1;
   localparam logic [1:0] MODE_LBA48 = 2'd2;

   // task-file registers
   localparam logic [2:0] REG_CONTROL  = 3'd0;
   localparam logic [2:0] REG_SELECT   = 3'd1;
   localparam logic [2:0] REG_COUNT    = 3'd2;
   localparam logic [2:0] REG_LBA_LOW  = 3'd3;
   localparam logic [2:0] REG_LBA_MID  = 3'd4;
   localparam logic [2:0] REG_LBA_HIGH = 3'd5;
   localparam logic [2:0] REG_COMMAND  = 3'd6;

   // sequencer steps
   localparam logic [3:0] STEP_CONTROL   = 4'd0;
   localparam logic [3:0] STEP_SELECT    = 4'd1;
   localparam logic [3:0] STEP_HOB_COUNT = 4'd2;
   localparam logic [3:0] STEP_HOB_LOW   = 4'd3;
   localparam logic [3:0] STEP_HOB_MID   = 4'd4;
   localparam logic [3:0] STEP_HOB_HIGH  = 4'd5;
   localparam logic [3:0] STEP_COUNT     = 4'd6;
   localparam logic [3:0] STEP_LOW       = 4'd7;
   localparam logic [3:0] STEP_MID       = 4'd8;
   localparam logic [3:0] STEP_HIGH      = 4'd9;
   localparam logic [3:0] STEP_COMMAND   = 4'd10;

   // data bytes
   localparam logic [7:0] CONTROL_NIEN = 8'h02;
   localparam logic [7:0] SELECT_CHS   = 8'hA0;
   localparam logic [7:0] SELECT_LBA   = 8'hE0;
   localparam logic [7:0] CMD_READ     = 8'h20;
   localparam logic [7:0] CMD_WRITE    = 8'h30;
   localparam logic [7:0] CMD_READ_EXT = 8'h24;
   localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

   // floor(a / 63) = (a * CHS_RECIP) >> CHS_SHIFT, exact for a < 2^28
   localparam logic [28:0] CHS_RECIP = 29'd272696337;
   localparam int          CHS_SHIFT = 34;
   localparam int          QUOT_W    = 23;

   typedef struct packed {
      logic [3:0] lba28_capable;
      logic [3:0] is_slave;
      logic [3:0] channel;
   } cfg_type;

   typedef struct packed {
      logic       chan;
      logic       lba48;
      logic [7:0] select;
      logic [7:0] count;
      logic [7:0] hob_low;
      logic [7:0] lba_low;
      logic [7:0] lba_mid;
      logic [7:0] lba_high;
      logic [7:0] command;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== src/tfcb_front.sv =====
// ----------------------------------------------------------------------------
// tfcb_front
// Accepts requests, picks the addressing mode and builds the command record.
// ----------------------------------------------------------------------------
module tfcb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  tfcb_pkg::cfg_type            cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tfcb_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  tfcb_pkg::qstat_type          qstat,
   output logic                         push,
   output tfcb_pkg::cmd_type            push_cmd
);
   import tfcb_pkg::*;

   logic [1:0]  drive;
   logic        dir;
   logic [31:0] addr;
   logic [7:0]  cnt;
   logic [56:0] product;
   logic        accept;

   logic              valid_ff, valid_in;
   logic [1:0]        mode_ff, mode_in;
   logic              chan_ff, slave_ff, dir_ff;
   logic [31:0]       addr_ff;
   logic [7:0]        cnt_ff;
   logic [QUOT_W-1:0] quot_ff;

   logic [5:0] remainder;
   logic [3:0] head;
   logic [7:0] cmd_byte;

   assign drive = req_tdata[1:0];
   assign dir   = req_tdata[2];
   assign addr  = req_tdata[34:3];
   assign cnt   = req_tdata[42:35];

   assign req_tready = !valid_ff || !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = valid_ff && !qstat.full;

   assign product = {29'd0, addr[27:0]} * {28'd0, CHS_RECIP};

   always_comb begin
      if (addr[31:28] != 4'd0) begin
         mode_in = MODE_LBA48;
      end else if (cfg.lba28_capable[drive]) begin
         mode_in = MODE_LBA28;
      end else begin
         mode_in = MODE_CHS;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= mode_in;
         chan_ff  <= cfg.channel[drive];
         slave_ff <= cfg.is_slave[drive];
         dir_ff   <= dir;
         addr_ff  <= addr;
         cnt_ff   <= cnt;
         quot_ff  <= product[CHS_SHIFT +: QUOT_W];
      end
   end

   // a mod 63 = a - 64q + q, and the result stays below 64
   assign remainder = addr_ff[5:0] + quot_ff[5:0];
   assign head      = quot_ff[3:0];

   always_comb begin
      if (mode_ff == MODE_LBA48) begin
         cmd_byte = dir_ff ? CMD_WRITE_EXT : CMD_READ_EXT;
      end else begin
         cmd_byte = dir_ff ? CMD_WRITE : CMD_READ;
      end
   end

   always_comb begin
      push_cmd.chan    = chan_ff;
      push_cmd.lba48   = (mode_ff == MODE_LBA48);
      push_cmd.count   = cnt_ff;
      push_cmd.hob_low = addr_ff[31:24];
      push_cmd.command = cmd_byte;
      unique case (mode_ff)
         MODE_LBA48: begin
            push_cmd.select   = SELECT_LBA | {3'd0, slave_ff, 4'd0};
            push_cmd.lba_low  = addr_ff[7:0];
            push_cmd.lba_mid  = addr_ff[15:8];
            push_cmd.lba_high = addr_ff[23:16];
         end
         MODE_LBA28: begin
            push_cmd.select   = SELECT_LBA | {3'd0, slave_ff, addr_ff[27:24]};
            push_cmd.lba_low  = addr_ff[7:0];
            push_cmd.lba_mid  = addr_ff[15:8];
            push_cmd.lba_high = addr_ff[23:16];
         end
         default: begin
            push_cmd.select   = SELECT_CHS | {3'd0, slave_ff, head};
            push_cmd.lba_low  = {2'd0, remainder} + 8'd1;
            push_cmd.lba_mid  = quot_ff[11:4];
            push_cmd.lba_high = quot_ff[19:12];
         end
      endcase
   end

endmodule

// ===== src/tfcb_queue.sv =====
// ----------------------------------------------------------------------------
// tfcb_queue
// Short FIFO of command records between the front and the sequencer.
// ----------------------------------------------------------------------------
module tfcb_queue #(
   parameter int DEPTH = tfcb_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tfcb_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output tfcb_pkg::cmd_type   head_cmd,
   output tfcb_pkg::qstat_type qstat
);
   import tfcb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type           store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   assign qstat.full  = (fill_ff == CNT_FULL);
   assign qstat.empty = (fill_ff == '0);
   assign head_cmd    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/tfcb_back.sv =====
// ----------------------------------------------------------------------------
// tfcb_back
// Sequencer that walks one command record out as task-file register writes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfcb_back (
   input  logic                             clock,
   input  logic                             reset,
   input  tfcb_pkg::cmd_type                head_cmd,
   input  tfcb_pkg::qstat_type              qstat,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tfcb_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // write_data
   output logic [tfcb_pkg::RSP_TUSER_W-1:0] rsp_tuser,   // channel, task_register, high_order
   output logic                             rsp_tlast
);
   import tfcb_pkg::*;

   logic [3:0] step_ff, step_in;
   logic       load;
   logic       valid_ff, valid_in;
   logic       chan_ff;
   logic [2:0] reg_ff, reg_in;
   logic       hob_ff, hob_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff;

   assign load = !qstat.empty && (!valid_ff || rsp_tready);
   assign pop  = load && (step_ff == STEP_COMMAND);

   always_comb begin
      step_in = step_ff;
      if (load) begin
         if (step_ff == STEP_COMMAND) begin
            step_in = STEP_CONTROL;
         end else if (step_ff == STEP_SELECT && !head_cmd.lba48) begin
            step_in = STEP_COUNT;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_comb begin
      hob_in = 1'b0;
      unique case (step_ff)
         STEP_CONTROL: begin
            reg_in  = REG_CONTROL;
            data_in = CONTROL_NIEN;
         end
         STEP_SELECT: begin
            reg_in  = REG_SELECT;
            data_in = head_cmd.select;
         end
         STEP_HOB_COUNT: begin
            reg_in  = REG_COUNT;
            hob_in  = 1'b1;
            data_in = 8'd0;
         end
         STEP_HOB_LOW: begin
            reg_in  = REG_LBA_LOW;
            hob_in  = 1'b1;
            data_in = head_cmd.hob_low;
         end
         STEP_HOB_MID: begin
            reg_in  = REG_LBA_MID;
            hob_in  = 1'b1;
            data_in = 8'd0;
         end
         STEP_HOB_HIGH: begin
            reg_in  = REG_LBA_HIGH;
            hob_in  = 1'b1;
            data_in = 8'd0;
         end
         STEP_COUNT: begin
            reg_in  = REG_COUNT;
            data_in = head_cmd.count;
         end
         STEP_LOW: begin
            reg_in  = REG_LBA_LOW;
            data_in = head_cmd.lba_low;
         end
         STEP_MID: begin
            reg_in  = REG_LBA_MID;
            data_in = head_cmd.lba_mid;
         end
         STEP_HIGH: begin
            reg_in  = REG_LBA_HIGH;
            data_in = head_cmd.lba_high;
         end
         STEP_COMMAND: begin
            reg_in  = REG_COMMAND;
            data_in = head_cmd.command;
         end
         default: begin
            reg_in  = REG_CONTROL;
            data_in = CONTROL_NIEN;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_CONTROL;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chan_ff <= head_cmd.chan;
         reg_ff  <= reg_in;
         hob_ff  <= hob_in;
         data_ff <= data_in;
         last_ff <= (step_ff == STEP_COMMAND);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {hob_ff, reg_ff, chan_ff};
   assign rsp_tlast  = last_ff;

   `TFCB_ASSERT(a_step_range, clock, reset, step_ff <= STEP_COMMAND, "sequencer step out of range")
   `TFCB_ASSERT(a_skip_hob, clock, reset,
      load && step_ff == STEP_SELECT && !head_cmd.lba48 |=> step_ff == STEP_COUNT,
      "short sequence did not skip the high-order writes")
   `TFCB_ASSERT(a_last_is_command, clock, reset,
      valid_ff && last_ff |-> reg_ff == REG_COMMAND && !hob_ff,
      "last write is not the command")
   `TFCB_ASSERT(a_pop_ends_item, clock, reset,
      pop |=> step_ff == STEP_CONTROL && valid_ff && last_ff,
      "record released before its command write")

endmodule

// ===== src/ata_taskfile_command_builder_core.sv =====
// ----------------------------------------------------------------------------
// ata_taskfile_command_builder_core
// Builds the ordered ATA PIO task-file register writes for one read or write request.
// ----------------------------------------------------------------------------
// Each request yields eleven register writes when the address needs LBA48 and
// seven otherwise, one write per clock from a registered output stage while
// records are queued and the result channel is not stalled. A request passes
// through the classify stage with the divide-by-63 multiplier, the record
// queue and the output register before its first write. The front takes new
// requests while the record queue has room, and the sequencer runs records
// back to back.
// ----------------------------------------------------------------------------
module ata_taskfile_command_builder_core #(
   parameter int QUEUE_DEPTH = tfcb_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [3:0]                       csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tfcb_pkg::REQ_TDATA_W-1:0] req_tdata,  // drive_index, direction,
                                                        // block_address, sector_count
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tfcb_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // write_data
   output logic [tfcb_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // channel, task_register, high_order
   output logic                             rsp_tlast   // is_last
);
   import tfcb_pkg::*;

   cfg_type   cfg_ff;
   qstat_type qstat;
   cmd_type   push_cmd;
   cmd_type   head_cmd;
   logic      push;
   logic      pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LBA28_CAPABLE: cfg_ff.lba28_capable <= csr_wdata;
            CSR_IS_SLAVE:      cfg_ff.is_slave      <= csr_wdata;
            CSR_CHANNEL:       cfg_ff.channel       <= csr_wdata;
            default: ;
         endcase
      end
   end

   tfcb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tfcb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   tfcb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
